/* hdl/ps2mct_pkg.sv */
// Shared types, constants and arithmetic helpers for the PS/2 cursor tracker.
package ps2mct_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int CFG_W       = 13;
    localparam int CMP_W       = (COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W;
    localparam int SUM_W       = CMP_W + 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = ((2 * COORD_WIDTH + 3 + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - 2 * COORD_WIDTH - 3;

    localparam logic [CFG_W-1:0]       WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0]       HEIGHT_RESET = CFG_W'(768);
    localparam logic [COORD_WIDTH-1:0] CMAX         = '1;
    localparam logic signed [SUM_W-1:0] OVF_ADD     = SUM_W'(255);

    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_DX   = 3'b010,
        PH_DY   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] dx;
        logic [7:0] dy;
    } pkt_t;

    function automatic logic signed [SUM_W-1:0] delta_of(
        input logic [7:0] b,
        input logic       neg,
        input logic       ovf
    );
        logic signed [SUM_W-1:0] d;
        d = neg ? $signed({{(SUM_W-8){1'b1}}, b}) : $signed({{(SUM_W-8){1'b0}}, b});
        if (ovf) begin
            d = neg ? (d - OVF_ADD) : (d + OVF_ADD);
        end
        return d;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [CFG_W-1:0]        size
    );
        logic [CMP_W-1:0]       size_m1;
        logic [CMP_W-1:0]       hi_w;
        logic [COORD_WIDTH-1:0] hi;
        logic [COORD_WIDTH-1:0] r;
        size_m1 = (size == '0) ? '0 : (CMP_W'(size) - CMP_W'(1));
        hi_w    = (size_m1 > CMP_W'(CMAX)) ? CMP_W'(CMAX) : size_m1;
        hi      = hi_w[COORD_WIDTH-1:0];
        if (v[SUM_W-1]) begin
            r = '0;
        end else if (v > $signed({{(SUM_W-COORD_WIDTH){1'b0}}, hi})) begin
            r = hi;
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/ps2mct_framer.sv */
// Byte framer: drops the first byte, gathers three-byte packets into a packet register.
module ps2mct_framer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         rx_byte,
    input  logic               out_ready,
    output logic               pkt_valid,
    output ps2mct_pkg::pkt_t   pkt
);
    import ps2mct_pkg::*;

    logic   skip_first_reg, skip_first_next;
    phase_t phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] dx_reg, dx_next;
    logic   pkt_valid_reg, pkt_valid_next;
    pkt_t   pkt_reg, pkt_next;
    logic   accept;
    logic   fire;

    assign s_tready = !pkt_valid_reg || out_ready;
    assign accept   = s_tvalid && s_tready;
    assign fire     = accept && !skip_first_reg && (phase_reg == PH_DY);

    always_comb begin
        skip_first_next = skip_first_reg;
        phase_next      = phase_reg;
        header_next     = header_reg;
        dx_next         = dx_reg;
        if (accept) begin
            if (skip_first_reg) begin
                skip_first_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_HEAD: begin
                        if (rx_byte[HDR_SYNC]) begin
                            header_next = rx_byte;
                            phase_next  = PH_DX;
                        end
                    end
                    PH_DX: begin
                        dx_next    = rx_byte;
                        phase_next = PH_DY;
                    end
                    PH_DY: begin
                        phase_next = PH_HEAD;
                    end
                    default: begin
                        phase_next = PH_HEAD;
                    end
                endcase
            end
        end
    end

    always_comb begin
        pkt_valid_next = pkt_valid_reg;
        pkt_next       = pkt_reg;
        if (fire) begin
            pkt_valid_next = 1'b1;
            pkt_next       = '{header: header_reg, dx: dx_reg, dy: rx_byte};
        end else if (out_ready) begin
            pkt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_first_reg <= 1'b1;
            phase_reg      <= PH_HEAD;
            pkt_valid_reg  <= 1'b0;
        end else begin
            skip_first_reg <= skip_first_next;
            phase_reg      <= phase_next;
            pkt_valid_reg  <= pkt_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        header_reg <= header_next;
        dx_reg     <= dx_next;
        pkt_reg    <= pkt_next;
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

`ifndef SYNTHESIS
    a_skip_once: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && skip_first_reg |=> !skip_first_reg)
        else $error("first byte not dropped exactly once");
    a_skip_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_first_reg |-> phase_reg == PH_HEAD)
        else $error("packet phase advanced before first byte dropped");
    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> pkt_valid_reg)
        else $error("completed packet not captured");
`endif

endmodule

/* hdl/ps2mct_tracker.sv */
// Cursor tracker: screen size registers, delta decode, position update and result register.
module ps2mct_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_index,
    input  logic [ps2mct_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                                pkt_valid,
    input  ps2mct_pkg::pkt_t                    pkt,
    output logic                                out_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ps2mct_pkg::COORD_WIDTH-1:0]  cursor_x,
    output logic [ps2mct_pkg::COORD_WIDTH-1:0]  cursor_y,
    output logic [2:0]                          buttons
);
    import ps2mct_pkg::*;

    logic [CFG_W-1:0]       width_reg, width_next;
    logic [CFG_W-1:0]       height_reg, height_next;
    logic [COORD_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [2:0]             buttons_reg, buttons_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   advance;
    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    assign out_ready = !m_valid_reg || m_ready;
    assign advance   = pkt_valid && out_ready;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_next  = cfg_wdata;
                REG_SCREEN_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        dx    = delta_of(pkt.dx, pkt.header[HDR_XSIGN], pkt.header[HDR_XOVF]);
        dy    = delta_of(pkt.dy, pkt.header[HDR_YSIGN], pkt.header[HDR_YOVF]);
        sum_x = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, pos_x_reg}) + dx;
        sum_y = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, pos_y_reg}) - dy;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (advance) begin
            pos_x_next   = clamp_coord(sum_x, width_reg);
            pos_y_next   = clamp_coord(sum_y, height_reg);
            buttons_next = {pkt.header[HDR_MIDDLE], pkt.header[HDR_RIGHT],
                            pkt.header[HDR_LEFT]};
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        buttons_reg <= buttons_next;
    end

    assign m_valid  = m_valid_reg;
    assign cursor_x = pos_x_reg;
    assign cursor_y = pos_y_reg;
    assign buttons  = buttons_reg;

`ifndef SYNTHESIS
    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("packet consumed without a result");
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("cursor moved without a packet");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !advance)
        else $error("pending result overwritten");
`endif

endmodule

/* hdl/ps2_mouse_packet_cursor_tracker_top.sv */
// PS/2 cursor tracker top level: byte framer followed by cursor tracker.
// Accepts one raw PS/2 byte per clock while not held off. The first byte after
// reset is dropped; after that, a byte with bit 3 set starts a three-byte packet
// (header, X, Y), other bytes are dropped while waiting for a header. The third
// byte of a packet is captured in a packet register, and from there the 9-bit
// deltas (plus 255 on overflow) move the cursor, clamped to [0, min(size-1,
// 4095)] of the configured screen, with a zero size treated as one. The result
// (position and the three buttons) is loaded into the output register once that
// register is free, and one byte per cycle can be sustained; only a stalled
// output register with a packet waiting holds off the input. The user must
// write screen width and height through the cfg port only while the block is
// idle; the block does not enforce this. They reset to 1024 by 768.
module ps2_mouse_packet_cursor_tracker_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [0:0]                         cfg_index,
    input  logic [ps2mct_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ps2mct_pkg::S_TDATA_W-1:0]   s_tdata,  // rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cursor_x, cursor_y, left_pressed, right_pressed, middle_pressed, zero pad
    output logic [ps2mct_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ps2mct_pkg::*;

    logic                   out_ready;
    logic                   pkt_valid;
    pkt_t                   pkt;
    logic [COORD_WIDTH-1:0] cursor_x;
    logic [COORD_WIDTH-1:0] cursor_y;
    logic [2:0]             buttons;

    ps2mct_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .rx_byte   (s_tdata),
        .out_ready (out_ready),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    ps2mct_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .out_ready (out_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .cursor_x  (cursor_x),
        .cursor_y  (cursor_y),
        .buttons   (buttons)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, buttons, cursor_y, cursor_x};

endmodule
